FILE: hw/rtl/fpt_pkg.sv
package fpt_pkg;

  localparam int NUM_FRAMES_DEF    = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int PN_W              = 40;
  localparam int ENTRY_W           = 64;
  localparam int PTR_FLAGS_W       = 12;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 52;

  localparam logic [PA_W-1:0]        TABLE_BASE_RST    = '0;
  localparam logic [PTR_FLAGS_W-1:0] POINTER_FLAGS_RST = 12'h003;
  // P, RW, US, PWT, PCD, A, D, PAT, G, XD
  localparam logic [ENTRY_W-1:0]     LEAF_FLAG_MASK    = 64'h8000_0000_0000_01FF;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_FULL       = 2'd2
  } status_t;

  typedef enum logic {
    OP_MAP   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_BASE    = 1'b0,
    CFG_POINTER_FLAGS = 1'b1
  } cfg_idx_t;

  // microprogram step addresses
  typedef enum logic [2:0] {
    U_CLR  = 3'd0,
    U_IDLE = 3'd1,
    U_RD   = 3'd2,
    U_EV   = 3'd3,
    U_FIN  = 3'd4
  } step_t;

  // jump conditions; when not taken the sequencer goes to step + 1
  typedef enum logic [2:0] {
    C_NEXT      = 3'd0,
    C_JUMP      = 3'd1,
    C_NO_START  = 3'd2,
    C_CLEARING  = 3'd3,
    C_WALK_MORE = 3'd4
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t tgt;
    logic  clr_wr;
    logic  idle;
    logic  rd;
    logic  ev;
    logic  fin;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic clearing;
    logic walk_more;
  } seq_cond_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{cond: C_JUMP, tgt: U_IDLE, clr_wr: 1'b0, idle: 1'b0, rd: 1'b0, ev: 1'b0,
          fin: 1'b0};
    unique case (s)
      U_CLR: begin
        w.cond   = C_CLEARING;
        w.tgt    = U_CLR;
        w.clr_wr = 1'b1;
      end
      U_IDLE: begin
        w.cond = C_NO_START;
        w.tgt  = U_IDLE;
        w.idle = 1'b1;
      end
      U_RD: begin
        w.cond = C_NEXT;
        w.rd   = 1'b1;
      end
      U_EV: begin
        w.cond = C_WALK_MORE;
        w.tgt  = U_RD;
        w.ev   = 1'b1;
      end
      U_FIN: begin
        w.cond = C_JUMP;
        w.tgt  = U_IDLE;
        w.fin  = 1'b1;
      end
      default: begin
        w.cond = C_JUMP;
        w.tgt  = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/fpt_useq.sv
module fpt_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  fpt_pkg::seq_cond_t cond_i,
  output fpt_pkg::ctrl_t    ctrl
);
  import fpt_pkg::*;

  step_t step_r, step_nxt;
  logic  take;

  assign ctrl = ucode(step_r);

  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:      take = 1'b0;
      C_JUMP:      take = 1'b1;
      C_NO_START:  take = ~cond_i.start;
      C_CLEARING:  take = cond_i.clearing;
      C_WALK_MORE: take = cond_i.walk_more;
      default:     take = 1'b1;
    endcase
    step_nxt = take ? ctrl.tgt : step_t'(3'(step_r) + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= U_CLR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: hw/rtl/four_level_page_table_mapper.sv
// Channel  | Ports                                            | Handshake
// request  | in_op, in_virt_addr, in_phys_addr, in_flags_in   | start & !busy
// result   | out_status, out_phys_out, out_flags_out          | out_valid, one cycle
// config   | cfg_idx, cfg_wdata                               | cfg_we
//
// After acceptance a query runs a read and an evaluate step per level, a map only for the
// three pointer levels, then a result step; the walk stops early on a missing entry or a
// full store. busy drops the cycle after the result, and only then is a new request taken.
// After reset busy stays high while the table store is cleared one entry per cycle;
// config writes are taken during that pass.
// Results cannot be stalled; out_valid is high for exactly one cycle per request.
module four_level_page_table_mapper #(
  parameter int NUM_FRAMES = fpt_pkg::NUM_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_op,
  input  logic [fpt_pkg::VA_W-1:0]       in_virt_addr,
  input  logic [fpt_pkg::PA_W-1:0]       in_phys_addr,
  input  logic [fpt_pkg::ENTRY_W-1:0]    in_flags_in,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [fpt_pkg::PA_W-1:0]       out_phys_out,
  output logic [fpt_pkg::ENTRY_W-1:0]    out_flags_out,
  input  logic                           cfg_we,
  input  logic [fpt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fpt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fpt_pkg::*;

  localparam int FW    = $clog2(NUM_FRAMES);
  localparam int NFW   = $clog2(NUM_FRAMES + 1);
  localparam int AW    = FW + IDX_W;
  localparam int DEPTH = NUM_FRAMES * ENTRIES_PER_TABLE;
  localparam logic [AW-1:0]  CLR_LAST   = AW'(DEPTH - 1);
  localparam logic [NFW-1:0] FRAMES_END = NFW'(NUM_FRAMES);

  ctrl_t     ctrl;
  seq_cond_t seq_cond;

  logic [ENTRY_W-1:0] store_mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  logic [PN_W-1:0]        base_r;
  logic [PTR_FLAGS_W-1:0] ptr_flags_r;
  logic [NFW-1:0]         next_frame_r;
  logic [AW-1:0]          clr_r;

  op_t                op_r;
  logic [VA_W-1:0]    va_r;
  logic [PN_W-1:0]    pn_r;
  logic [ENTRY_W-1:0] fl_r;
  logic [1:0]         level_r;
  logic [FW-1:0]      frame_r;
  status_t            st_r;
  logic [PA_W-1:0]    phys_r;
  logic [ENTRY_W-1:0] flags_r;

  logic               accept;
  logic [IDX_W-1:0]   idx;
  logic [AW-1:0]      slot;
  logic [PN_W-1:0]    rel;
  logic               follow_ok;
  logic               is_leaf;
  logic               frames_full;
  logic               alloc;
  logic               last_ptr;
  logic               walk_more;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [PN_W-1:0]    new_frame_pn;

  fpt_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cond_i (seq_cond),
    .ctrl   (ctrl)
  );

  assign busy   = ~ctrl.idle;
  assign accept = ctrl.idle & start;

  always_comb begin
    case (level_r)
      2'd0:    idx = va_r[47:39];
      2'd1:    idx = va_r[38:30];
      2'd2:    idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
  end

  assign slot = {frame_r, idx};

  // decode of the entry read for this level
  assign rel          = rd_data_r[51:12] - base_r;
  assign follow_ok    = rd_data_r[0] & (rel < PN_W'(NUM_FRAMES));
  assign is_leaf      = (level_r == 2'd3);
  assign frames_full  = (next_frame_r == FRAMES_END);
  assign last_ptr     = (op_r == OP_MAP) && (level_r == 2'd2);
  assign alloc        = ctrl.ev & ~is_leaf & ~follow_ok & (op_r == OP_MAP) & ~frames_full;
  assign new_frame_pn = base_r + PN_W'(next_frame_r);

  always_comb begin
    walk_more = 1'b0;
    if (!is_leaf && !last_ptr) begin
      walk_more = follow_ok | alloc;
    end
  end

  assign seq_cond.start     = start;
  assign seq_cond.clearing  = (clr_r != CLR_LAST);
  assign seq_cond.walk_more = walk_more;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = {12'd0, pn_r, 12'd0} | fl_r;
    if (ctrl.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (alloc) begin
      wr_en   = 1'b1;
      wr_data = {12'd0, new_frame_pn, ptr_flags_r | 12'h001};
    end else if (ctrl.fin && op_r == OP_MAP && st_r == ST_OK) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd) begin
      rd_data_r <= store_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= TABLE_BASE_RST[51:12];
      ptr_flags_r  <= POINTER_FLAGS_RST;
      next_frame_r <= NFW'(1);
      clr_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_TABLE_BASE:    base_r      <= cfg_wdata[51:12];
          CFG_POINTER_FLAGS: ptr_flags_r <= cfg_wdata[PTR_FLAGS_W-1:0];
          default:           ;
        endcase
      end
      if (ctrl.clr_wr) begin
        clr_r <= clr_r + AW'(1);
      end
      if (alloc) begin
        next_frame_r <= next_frame_r + NFW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_op);
      va_r    <= in_virt_addr;
      pn_r    <= in_phys_addr[51:12];
      fl_r    <= in_flags_in;
      level_r <= 2'd0;
      frame_r <= '0;
      st_r    <= ST_OK;
      phys_r  <= '0;
      flags_r <= '0;
    end else if (ctrl.ev) begin
      if (is_leaf) begin
        if (rd_data_r[0]) begin
          phys_r  <= {rd_data_r[51:12], 12'd0};
          flags_r <= rd_data_r & LEAF_FLAG_MASK;
        end else begin
          st_r <= ST_NOT_MAPPED;
        end
      end else if (follow_ok) begin
        frame_r <= rel[FW-1:0];
        level_r <= level_r + 2'd1;
      end else if (op_r == OP_QUERY) begin
        st_r <= ST_NOT_MAPPED;
      end else if (frames_full) begin
        st_r <= ST_FULL;
      end else begin
        frame_r <= next_frame_r[FW-1:0];
        level_r <= level_r + 2'd1;
      end
    end
  end

  assign out_valid     = ctrl.fin;
  assign out_status    = st_r;
  assign out_phys_out  = phys_r;
  assign out_flags_out = flags_r;

endmodule
